[rtl/core/oat_pkg.sv]
package oat_pkg;

   localparam int DEPTH = 16;
   localparam int POS_W = 4;
   localparam int CNT_W = 5;
   localparam int VAL_W = 32;
   localparam int OP_W  = 2;
   localparam int ST_W  = 2;

   typedef enum logic [OP_W-1:0] {
      OP_APPEND = 2'd0,
      OP_INSERT = 2'd1,
      OP_DELETE = 2'd2,
      OP_SEARCH = 2'd3
   } op_type;

   typedef enum logic [ST_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2,
      ST_MISS  = 2'd3
   } status_type;

   // Command broadcast to every cell of the chain.
   typedef struct packed {
      logic             do_append;
      logic             do_insert;
      logic             do_delete;
      logic             do_search;
      logic [POS_W-1:0] position;
      logic [CNT_W-1:0] count;
   } cell_cmd_type;

endpackage

[rtl/core/oat_if.sv]
interface oat_req_if;
   import oat_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [OP_W-1:0]         opcode;
   logic [POS_W-1:0]        position;
   logic signed [VAL_W-1:0] value;
   modport source (output valid, output opcode, output position, output value, input ready);
   modport sink (input valid, input opcode, input position, input value, output ready);
endinterface

interface oat_rsp_if;
   import oat_pkg::*;
   logic             valid;
   logic             ready;
   logic [ST_W-1:0]  status;
   logic [POS_W-1:0] found_index;
   logic [CNT_W-1:0] count;
   modport source (output valid, output status, output found_index, output count, input ready);
   modport sink (input valid, input status, input found_index, input count, output ready);
endinterface

interface oat_csr_if;
   import oat_pkg::*;
   logic             valid;
   logic             ready;
   logic [CNT_W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

[rtl/core/oat_cell.sv]
module oat_cell #(
   parameter int WIDTH = 32,
   parameter int INDEX = 0
) (
   input  logic                 clock,
   input  oat_pkg::cell_cmd_type cmd,
   input  logic [WIDTH-1:0]     key,
   input  logic [WIDTH-1:0]     left_data,
   input  logic [WIDTH-1:0]     right_data,
   output logic [WIDTH-1:0]     data_out,
   output logic                 match_out
);
   import oat_pkg::*;

   logic [WIDTH-1:0] entry_ff;
   logic [WIDTH-1:0] entry_in;
   logic             match_ff;
   logic             match_in;
   logic             at_pos;
   logic             above_pos;
   logic             at_end;
   logic             in_use;

   assign at_pos    = (INDEX == int'(cmd.position));
   assign above_pos = (INDEX > int'(cmd.position));
   assign at_end    = (INDEX == int'(cmd.count));
   assign in_use    = (INDEX < int'(cmd.count));

   always_comb begin
      priority if ((cmd.do_append && at_end) || (cmd.do_insert && at_pos)) begin
         entry_in = key;
      end else if (cmd.do_insert && above_pos) begin
         entry_in = left_data;
      end else if (cmd.do_delete && (at_pos || above_pos)) begin
         entry_in = right_data;
      end else begin
         entry_in = entry_ff;
      end
   end

   assign match_in = cmd.do_search ? (in_use && (entry_ff == key)) : match_ff;

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      match_ff <= match_in;
   end

   assign data_out  = entry_ff;
   assign match_out = match_ff;

endmodule

[rtl/core/ordered_array_table.sv]
// Ordered array table: a packed array of up to 16 signed entries with a count, held in a
// row of cells. Append, insert, delete and search each give one result. The block takes one
// item per clock cycle sustained while the receiver keeps ready high. A result passes through a
// pending register and then the output register: at the accepting edge every cell updates and
// compares at once; once the output register can take it, the lowest matching cell is picked.
// Reset clears the count and sets the capacity to 16; entries hold no defined value until
// written. A capacity above 16 acts as 16, and a capacity of zero keeps the table full.
module ordered_array_table #(
   parameter int WIDTH = 32
) (
   input  logic     clock,
   input  logic     reset,
   oat_req_if.sink  req_bus,
   oat_rsp_if.source rsp_bus,
   oat_csr_if.sink  csr_bus
);
   import oat_pkg::*;

   localparam int CAP_MAX = (DEPTH < 31) ? DEPTH : 31;

   logic [CNT_W-1:0] capacity_ff;
   logic [CNT_W-1:0] capacity_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [CNT_W-1:0] eff_cap;
   logic             full;
   logic             accept;
   logic             move;
   op_type           op;
   status_type       op_status;
   logic [CNT_W-1:0] op_count;
   logic             op_write;
   logic             pend_valid_ff;
   logic             pend_valid_in;
   logic             pend_search_ff;
   status_type       pend_status_ff;
   logic [CNT_W-1:0] pend_count_ff;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   status_type       rsp_status_ff;
   status_type       rsp_status_in;
   logic [POS_W-1:0] rsp_index_ff;
   logic [POS_W-1:0] rsp_index_in;
   logic [CNT_W-1:0] rsp_count_ff;
   logic             hit;
   logic [POS_W-1:0] hit_index;
   logic signed [63:0] value_ext;
   logic [WIDTH-1:0] key;
   cell_cmd_type     cmd;
   logic [WIDTH-1:0] cell_data [DEPTH];
   logic [DEPTH-1:0] match;

   assign eff_cap = (int'(capacity_ff) > CAP_MAX) ? CNT_W'(CAP_MAX) : capacity_ff;
   assign full    = (count_ff >= eff_cap);
   assign op      = op_type'(req_bus.opcode);
   assign move    = pend_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !pend_valid_ff || move;
   assign accept  = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   assign value_ext = 64'(req_bus.value);
   assign key       = value_ext[WIDTH-1:0];

   always_comb begin
      op_status = ST_OK;
      op_count  = count_ff;
      op_write  = 1'b0;
      unique case (op)
         OP_APPEND: begin
            if (full) begin
               op_status = ST_FULL;
            end else begin
               op_write = 1'b1;
               op_count = count_ff + 1'b1;
            end
         end
         OP_INSERT: begin
            if ({1'b0, req_bus.position} > count_ff) begin
               op_status = ST_RANGE;
            end else if (full) begin
               op_status = ST_FULL;
            end else begin
               op_write = 1'b1;
               op_count = count_ff + 1'b1;
            end
         end
         OP_DELETE: begin
            if ({1'b0, req_bus.position} >= count_ff) begin
               op_status = ST_RANGE;
            end else begin
               op_write = 1'b1;
               op_count = count_ff - 1'b1;
            end
         end
         OP_SEARCH: begin
            op_status = ST_MISS;
         end
      endcase
   end

   always_comb begin
      cmd.do_append = accept && op_write && (op == OP_APPEND);
      cmd.do_insert = accept && op_write && (op == OP_INSERT);
      cmd.do_delete = accept && op_write && (op == OP_DELETE);
      cmd.do_search = accept && (op == OP_SEARCH);
      cmd.position  = req_bus.position;
      cmd.count     = count_ff;
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      oat_cell #(
         .WIDTH (WIDTH),
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .key        (key),
         .left_data  (cell_data[(i == 0) ? i : i - 1]),
         .right_data (cell_data[(i == DEPTH - 1) ? i : i + 1]),
         .data_out   (cell_data[i]),
         .match_out  (match[i])
      );
   end

   always_comb begin
      hit       = 1'b0;
      hit_index = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (match[i]) begin
            hit       = 1'b1;
            hit_index = POS_W'(i);
         end
      end
   end

   always_comb begin
      rsp_status_in = pend_status_ff;
      rsp_index_in  = '0;
      if (pend_search_ff && hit) begin
         rsp_status_in = ST_OK;
         rsp_index_in  = hit_index;
      end
   end

   assign count_in      = accept ? op_count : count_ff;
   assign capacity_in   = csr_bus.valid ? csr_bus.data : capacity_ff;
   assign pend_valid_in = accept ? 1'b1 : (move ? 1'b0 : pend_valid_ff);
   assign rsp_valid_in  = move ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff   <= CNT_W'(16);
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         capacity_ff   <= capacity_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pend_search_ff <= (op == OP_SEARCH);
         pend_status_ff <= op_status;
         pend_count_ff  <= op_count;
      end
      if (move) begin
         rsp_status_ff <= rsp_status_in;
         rsp_index_ff  <= rsp_index_in;
         rsp_count_ff  <= pend_count_ff;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = rsp_status_ff;
   assign rsp_bus.found_index = rsp_index_ff;
   assign rsp_bus.count       = rsp_count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      int'(count_ff) <= CAP_MAX)
      else $error("entry count exceeds table depth");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !reset && !accept |=> $stable(count_ff))
      else $error("entry count changed without an accepted item");

   a_append_grows: assert property (@(posedge clock) disable iff (reset)
      !reset && accept && (op == OP_APPEND) && !full |=> count_ff == $past(count_ff) + 1'b1)
      else $error("append did not grow the table by one");

   a_pend_after_accept: assert property (@(posedge clock) disable iff (reset)
      !reset && accept |=> pend_valid_ff)
      else $error("accepted item was not held for its result");

   a_index_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff != ST_OK) |-> rsp_index_ff == '0)
      else $error("failed operation reports a nonzero index");

endmodule
